>>> rtl/first_fit_page_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit page allocator.
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold in the same cycle.
`define FFPA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ffpa assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define FFPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ffpa assertion failed");

`endif

>>> rtl/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared constants, status codes, and the command/status structs that join
// the allocator controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffpa_pkg;

  localparam int PAGE_BYTES  = 4096;
  localparam int MIN_BLOCK   = 8;
  localparam int TABLE_DEPTH = 512;

  localparam int OFF_W  = 12;
  localparam int SIZE_W = 13;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_NO_FIT   = 2'd2;
  localparam logic [1:0] ST_NO_CHUNK = 2'd3;

  // Table access selected by the controller for one cycle.
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_CLR      = 4'd1;
  localparam logic [3:0] OP_RD_CUR   = 4'd2;
  localparam logic [3:0] OP_RD_SCAN  = 4'd3;
  localparam logic [3:0] OP_RD_NXT   = 4'd4;
  localparam logic [3:0] OP_RD_SUCC  = 4'd5;
  localparam logic [3:0] OP_WR_EXACT = 4'd6;
  localparam logic [3:0] OP_WR_NEW   = 4'd7;
  localparam logic [3:0] OP_WR_SPLIT = 4'd8;
  localparam logic [3:0] OP_WR_PLINK = 4'd9;
  localparam logic [3:0] OP_WR_SURV  = 4'd10;
  localparam logic [3:0] OP_WR_DEADC = 4'd11;
  localparam logic [3:0] OP_WR_DEADN = 4'd12;
  localparam logic [3:0] OP_WR_SUCC  = 4'd13;

  typedef struct packed {
    logic [3:0] ram_op;
    logic       ld_req;
    logic       start;
    logic       ld_cur;
    logic       adv;
    logic       ld_nxt;
    logic       ld_succ;
    logic       scan_clr;
    logic       scan_inc;
    logic       ld_new;
    logic       head_new;
    logic       res_set;
    logic [1:0] res_code;
    logic       res_grant;
    logic       out_ld;
  } ffpa_cmd_t;

  typedef struct packed {
    logic is_free;
    logic bad_size;
    logic ev_fit;
    logic ev_exact;
    logic ev_match;
    logic ev_has_next;
    logic has_prev;
    logic slot_free;
    logic scan_last;
    logic prv_merge;
    logic nx_merge;
    logic succ_exists;
  } ffpa_sts_t;

endpackage

`default_nettype wire

>>> rtl/ffpa_ram.sv
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ffpa_dp.sv
// ----------------------------------------------------------------------------
// ffpa_dp
// Allocator datapath: request and walk registers, chunk table, link updates
// and result registers, driven by commands from the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffpa_dp
  import ffpa_pkg::*;
#(
  parameter int TableDepth = TABLE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_type_i,
  input  wire logic [SIZE_W-1:0] req_size_i,
  input  wire logic [OFF_W-1:0]  req_offset_i,
  input  wire ffpa_cmd_t         cmd_i,
  output ffpa_sts_t              sts_o,
  output logic      [1:0]        status_o,
  output logic      [OFF_W-1:0]  grant_offset_o
);

  localparam int IW = $clog2(TableDepth);

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic              in_use;
    logic              allocated;
    logic              has_next;
    logic              has_prev;
    logic [IW-1:0]     next;
    logic [IW-1:0]     prev;
  } entry_t;

  localparam int EW = $bits(entry_t);

  logic              req_type_q;
  logic [SIZE_W-1:0] req_size_q;
  logic [OFF_W-1:0]  req_off_q;
  logic [IW-1:0]     head_q, cur_idx_q, prv_idx_q, new_idx_q, scan_q;
  entry_t            cur_q, prv_q, nxt_q, succ_q, rdata;
  logic [1:0]        res_status_q, out_status_q;
  logic [OFF_W-1:0]  res_grant_q, out_grant_q;

  logic              ram_we;
  logic [IW-1:0]     ram_addr;
  entry_t            ram_wdata;
  logic [EW-1:0]     ram_rdata;

  logic              prv_merge, nx_merge, tail_has_next;
  logic [IW-1:0]     tail_next, surv_idx;
  logic [SIZE_W-1:0] merged_size;
  entry_t            init_e, new_e, split_e, plink_e, surv_e, succ_e, exact_e;

  assign rdata = entry_t'(ram_rdata);

  // Merge bookkeeping for a free: the leftmost free chunk survives.
  always_comb begin
    prv_merge     = cur_q.has_prev && !prv_q.allocated;
    nx_merge      = cur_q.has_next && !nxt_q.allocated;
    tail_has_next = nx_merge ? nxt_q.has_next : cur_q.has_next;
    tail_next     = nx_merge ? nxt_q.next : cur_q.next;
    surv_idx      = prv_merge ? prv_idx_q : cur_idx_q;
    merged_size   = cur_q.size + (nx_merge ? nxt_q.size : '0)
                  + (prv_merge ? prv_q.size : '0);

    init_e        = '0;
    init_e.size   = SIZE_W'(PAGE_BYTES);
    init_e.in_use = 1'b1;

    exact_e           = cur_q;
    exact_e.allocated = 1'b1;

    new_e           = '0;
    new_e.offset    = cur_q.offset;
    new_e.size      = req_size_q;
    new_e.in_use    = 1'b1;
    new_e.allocated = 1'b1;
    new_e.has_next  = 1'b1;
    new_e.next      = cur_idx_q;
    new_e.has_prev  = cur_q.has_prev;
    new_e.prev      = cur_q.prev;

    split_e          = cur_q;
    split_e.offset   = OFF_W'(cur_q.offset + req_size_q);
    split_e.size     = cur_q.size - req_size_q;
    split_e.has_prev = 1'b1;
    split_e.prev     = new_idx_q;

    plink_e      = prv_q;
    plink_e.next = new_idx_q;

    surv_e           = prv_merge ? prv_q : cur_q;
    surv_e.allocated = 1'b0;
    surv_e.size      = merged_size;
    surv_e.has_next  = tail_has_next;
    surv_e.next      = tail_next;

    succ_e          = succ_q;
    succ_e.has_prev = 1'b1;
    succ_e.prev     = surv_idx;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cur_idx_q;
    ram_wdata = '0;
    unique case (cmd_i.ram_op)
      OP_NONE:     ram_we = 1'b0;
      OP_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = scan_q;
        ram_wdata = (scan_q == '0) ? init_e : '0;
      end
      OP_RD_CUR:   ram_addr = cur_idx_q;
      OP_RD_SCAN:  ram_addr = scan_q;
      OP_RD_NXT:   ram_addr = cur_q.next;
      OP_RD_SUCC:  ram_addr = tail_next;
      OP_WR_EXACT: begin
        ram_we = 1'b1; ram_addr = cur_idx_q; ram_wdata = exact_e;
      end
      OP_WR_NEW: begin
        ram_we = 1'b1; ram_addr = new_idx_q; ram_wdata = new_e;
      end
      OP_WR_SPLIT: begin
        ram_we = 1'b1; ram_addr = cur_idx_q; ram_wdata = split_e;
      end
      OP_WR_PLINK: begin
        ram_we = 1'b1; ram_addr = prv_idx_q; ram_wdata = plink_e;
      end
      OP_WR_SURV: begin
        ram_we = 1'b1; ram_addr = surv_idx; ram_wdata = surv_e;
      end
      OP_WR_DEADC: begin
        ram_we = 1'b1; ram_addr = cur_idx_q; ram_wdata = '0;
      end
      OP_WR_DEADN: begin
        ram_we = 1'b1; ram_addr = cur_q.next; ram_wdata = '0;
      end
      OP_WR_SUCC: begin
        ram_we = 1'b1; ram_addr = tail_next; ram_wdata = succ_e;
      end
      default:     ram_we = 1'b0;
    endcase
  end

  ffpa_ram #(
    .Width(EW),
    .Depth(TableDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(EW'(ram_wdata)),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      scan_q <= '0;
    end else begin
      if (cmd_i.head_new) head_q <= new_idx_q;
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) begin
      req_type_q <= req_type_i;
      req_size_q <= req_size_i;
      req_off_q  <= req_offset_i;
    end
    if (cmd_i.start) cur_idx_q <= head_q;
    if (cmd_i.ld_cur) cur_q <= rdata;
    if (cmd_i.adv) begin
      prv_q     <= rdata;
      prv_idx_q <= cur_idx_q;
      cur_idx_q <= rdata.next;
    end
    if (cmd_i.ld_nxt) nxt_q <= rdata;
    if (cmd_i.ld_succ) succ_q <= rdata;
    if (cmd_i.ld_new) new_idx_q <= scan_q;
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_code;
      res_grant_q  <= cmd_i.res_grant ? cur_q.offset : '0;
    end
    if (cmd_i.out_ld) begin
      out_status_q <= res_status_q;
      out_grant_q  <= res_grant_q;
    end
  end

  // Fields named ev_* look at the entry arriving from the table this cycle.
  always_comb begin
    sts_o.is_free     = req_type_q;
    sts_o.bad_size    = (req_size_q == '0)
                     || ((req_size_q & SIZE_W'(MIN_BLOCK - 1)) != '0)
                     || (req_size_q > SIZE_W'(PAGE_BYTES));
    sts_o.ev_fit      = !rdata.allocated && (rdata.size >= req_size_q);
    sts_o.ev_exact    = (rdata.size == req_size_q);
    sts_o.ev_match    = rdata.in_use && (rdata.offset == req_off_q);
    sts_o.ev_has_next = rdata.has_next;
    sts_o.has_prev    = cur_q.has_prev;
    sts_o.slot_free   = !rdata.in_use;
    sts_o.scan_last   = (scan_q == IW'(TableDepth - 1));
    sts_o.prv_merge   = prv_merge;
    sts_o.nx_merge    = nx_merge;
    sts_o.succ_exists = tail_has_next;
  end

  assign status_o       = out_status_q;
  assign grant_offset_o = out_grant_q;

endmodule

`default_nettype wire

>>> rtl/ffpa_ctrl.sv
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Allocator controller: table clear after reset, list walk, free-slot scan,
// split and merge write sequences, and the result handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire ffpa_sts_t sts_i,
  output ffpa_cmd_t      cmd_o
);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_CHK  = 5'd2;
  localparam logic [4:0] S_RD   = 5'd3;
  localparam logic [4:0] S_EV   = 5'd4;
  localparam logic [4:0] S_WEX  = 5'd5;
  localparam logic [4:0] S_FRD  = 5'd6;
  localparam logic [4:0] S_FEV  = 5'd7;
  localparam logic [4:0] S_WN   = 5'd8;
  localparam logic [4:0] S_WC   = 5'd9;
  localparam logic [4:0] S_WP   = 5'd10;
  localparam logic [4:0] S_NRD  = 5'd11;
  localparam logic [4:0] S_NEV  = 5'd12;
  localparam logic [4:0] S_SRD  = 5'd13;
  localparam logic [4:0] S_SEV  = 5'd14;
  localparam logic [4:0] S_WS   = 5'd15;
  localparam logic [4:0] S_WD1  = 5'd16;
  localparam logic [4:0] S_WD2  = 5'd17;
  localparam logic [4:0] S_WX   = 5'd18;
  localparam logic [4:0] S_RES  = 5'd19;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.ram_op   = OP_CLR;
        cmd_o.scan_inc = 1'b1;
        if (sts_i.scan_last) begin
          cmd_o.scan_clr = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_req = 1'b1;
          state_d      = S_CHK;
        end
      end
      S_CHK: begin
        if (!sts_i.is_free && sts_i.bad_size) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ST_BAD_SIZE;
          state_d        = S_RES;
        end else begin
          cmd_o.start = 1'b1;
          state_d     = S_RD;
        end
      end
      S_RD: begin
        cmd_o.ram_op = OP_RD_CUR;
        state_d      = S_EV;
      end
      S_EV: begin
        cmd_o.ld_cur = 1'b1;
        if (sts_i.is_free) begin
          if (sts_i.ev_match) begin
            state_d = sts_i.ev_has_next ? S_NRD : S_SRD;
          end else if (sts_i.ev_has_next) begin
            cmd_o.adv = 1'b1;
            state_d   = S_RD;
          end else begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = ST_NO_CHUNK;
            state_d        = S_RES;
          end
        end else if (sts_i.ev_fit) begin
          if (sts_i.ev_exact) begin
            state_d = S_WEX;
          end else begin
            cmd_o.scan_clr = 1'b1;
            state_d        = S_FRD;
          end
        end else if (sts_i.ev_has_next) begin
          cmd_o.adv = 1'b1;
          state_d   = S_RD;
        end else begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ST_NO_FIT;
          state_d        = S_RES;
        end
      end
      S_WEX: begin
        cmd_o.ram_op    = OP_WR_EXACT;
        cmd_o.res_set   = 1'b1;
        cmd_o.res_code  = ST_DONE;
        cmd_o.res_grant = 1'b1;
        state_d         = S_RES;
      end
      S_FRD: begin
        cmd_o.ram_op = OP_RD_SCAN;
        state_d      = S_FEV;
      end
      S_FEV: begin
        if (sts_i.slot_free) begin
          cmd_o.ld_new = 1'b1;
          state_d      = S_WN;
        end else if (sts_i.scan_last) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ST_NO_FIT;
          state_d        = S_RES;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = S_FRD;
        end
      end
      S_WN: begin
        cmd_o.ram_op = OP_WR_NEW;
        state_d      = S_WC;
      end
      S_WC: begin
        cmd_o.ram_op = OP_WR_SPLIT;
        if (sts_i.has_prev) begin
          state_d = S_WP;
        end else begin
          // The new chunk becomes the first one in the list.
          cmd_o.head_new  = 1'b1;
          cmd_o.res_set   = 1'b1;
          cmd_o.res_code  = ST_DONE;
          cmd_o.res_grant = 1'b1;
          state_d         = S_RES;
        end
      end
      S_WP: begin
        cmd_o.ram_op    = OP_WR_PLINK;
        cmd_o.res_set   = 1'b1;
        cmd_o.res_code  = ST_DONE;
        cmd_o.res_grant = 1'b1;
        state_d         = S_RES;
      end
      S_NRD: begin
        cmd_o.ram_op = OP_RD_NXT;
        state_d      = S_NEV;
      end
      S_NEV: begin
        cmd_o.ld_nxt = 1'b1;
        state_d      = S_SRD;
      end
      S_SRD: begin
        if (sts_i.succ_exists) begin
          cmd_o.ram_op = OP_RD_SUCC;
          state_d      = S_SEV;
        end else begin
          state_d = S_WS;
        end
      end
      S_SEV: begin
        cmd_o.ld_succ = 1'b1;
        state_d       = S_WS;
      end
      S_WS: begin
        cmd_o.ram_op = OP_WR_SURV;
        state_d      = S_WD1;
      end
      S_WD1: begin
        if (sts_i.prv_merge) cmd_o.ram_op = OP_WR_DEADC;
        state_d = S_WD2;
      end
      S_WD2: begin
        if (sts_i.nx_merge) cmd_o.ram_op = OP_WR_DEADN;
        state_d = S_WX;
      end
      S_WX: begin
        if (sts_i.succ_exists) cmd_o.ram_op = OP_WR_SUCC;
        cmd_o.res_set  = 1'b1;
        cmd_o.res_code = ST_DONE;
        state_d        = S_RES;
      end
      S_RES: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`include "first_fit_page_allocator_assert.svh"

  `FFPA_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni,
    in_valid_i && in_ready_o, state_q == S_CHK)
  `FFPA_ASSERT_SAME(a_out_load_slot_free, clk_i, rst_ni,
    cmd_o.out_ld, !out_valid_q || out_ready_i)
  `FFPA_ASSERT_NEXT(a_clear_runs_through, clk_i, rst_ni,
    (state_q == S_CLR) && !sts_i.scan_last, state_q == S_CLR)

endmodule

`default_nettype wire

>>> rtl/first_fit_page_allocator.sv
// First-fit page allocator with coalescing. One allocate or free request is
// worked at a time and yields one result beat. After reset every chunk table
// entry is cleared before the first request is taken. The chunk list is walked
// from its head through the single table port, with a read and an evaluate
// state for each chunk; a split allocate adds a search for the lowest unused
// slot and up to three writes, and a free adds link reads and merge writes.
// A finished result waits in an output register.
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// Top level: joins the allocator controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_page_allocator
  import ffpa_pkg::*;
#(
  parameter int TableDepth = TABLE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              req_type_i,
  input  wire logic [SIZE_W-1:0] req_size_i,
  input  wire logic [OFF_W-1:0]  req_offset_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [1:0]        status_o,
  output logic      [OFF_W-1:0]  grant_offset_o
);

  ffpa_cmd_t cmd;
  ffpa_sts_t sts;

  ffpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffpa_dp #(
    .TableDepth(TableDepth)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (req_type_i),
    .req_size_i    (req_size_i),
    .req_offset_i  (req_offset_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .grant_offset_o(grant_offset_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/first_fit_page_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit page allocator testbench
// Drives allocate and free requests through the valid/ready ports. A model of
// the chunk list predicts the status and grant offset of every request, and a
// scoreboard compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------

module first_fit_page_allocator_test;
  import ffpa_pkg::*;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct {
    logic [1:0]       status;
    logic [OFF_W-1:0] grant;
  } alloc_result_t;

  typedef struct {
    int unsigned offset;
    int unsigned size;
    bit          in_use;
    bit          taken;
    bit          has_next;
    bit          has_prev;
    int unsigned next;
    int unsigned prev;
  } chunk_t;

  class alloc_scoreboard;
    chunk_t          chunks[TABLE_DEPTH];
    int unsigned     head;
    alloc_result_t   pending[$];
    int              errors;

    function void clear_page();
      foreach (chunks[i]) chunks[i] = '{default: 0};
      chunks[0].size   = PAGE_BYTES;
      chunks[0].in_use = 1;
      head   = 0;
      errors = 0;
    endfunction

    function int lowest_unused();
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (!chunks[i].in_use) return i;
      return -1;
    endfunction

    function void merge_free_runs();
      int unsigned cur;
      int unsigned d;
      int unsigned guard;
      cur = head;
      guard = 0;
      while (cur < TABLE_DEPTH && guard < 2 * TABLE_DEPTH) begin
        guard++;
        if (!chunks[cur].taken && chunks[cur].has_next && chunks[cur].next < TABLE_DEPTH &&
            !chunks[chunks[cur].next].taken) begin
          d = chunks[cur].next;
          chunks[cur].size += chunks[d].size;
          chunks[cur].has_next = chunks[d].has_next;
          chunks[cur].next = chunks[d].next;
          if (chunks[d].has_next && chunks[d].next < TABLE_DEPTH) begin
            chunks[chunks[d].next].has_prev = 1;
            chunks[chunks[d].next].prev = cur;
          end
          chunks[d] = '{default: 0};
          continue;
        end
        if (!chunks[cur].has_next) break;
        cur = chunks[cur].next;
      end
    endfunction

    function alloc_result_t allocate(int unsigned size);
      alloc_result_t r;
      int unsigned cur;
      int ni;
      r.status = ST_NO_FIT;
      r.grant  = '0;
      if (size == 0 || size % MIN_BLOCK != 0 || size > PAGE_BYTES) begin
        r.status = ST_BAD_SIZE;
        return r;
      end
      cur = head;
      for (int steps = 0; steps < TABLE_DEPTH && cur < TABLE_DEPTH; steps++) begin
        if (!chunks[cur].taken && chunks[cur].size >= size) begin
          if (chunks[cur].size == size) begin
            chunks[cur].taken = 1;
            r.status = ST_DONE;
            r.grant  = chunks[cur].offset[OFF_W-1:0];
            return r;
          end
          ni = lowest_unused();
          if (ni < 0) return r;
          chunks[ni].offset   = chunks[cur].offset;
          chunks[ni].size     = size;
          chunks[ni].in_use   = 1;
          chunks[ni].taken    = 1;
          chunks[ni].has_next = 1;
          chunks[ni].next     = cur;
          chunks[ni].has_prev = chunks[cur].has_prev;
          chunks[ni].prev     = chunks[cur].prev;
          if (chunks[cur].has_prev && chunks[cur].prev < TABLE_DEPTH)
            chunks[chunks[cur].prev].next = ni;
          else
            head = ni;
          chunks[cur].has_prev = 1;
          chunks[cur].prev     = ni;
          chunks[cur].offset  += size;
          chunks[cur].size    -= size;
          r.status = ST_DONE;
          r.grant  = chunks[ni].offset[OFF_W-1:0];
          return r;
        end
        if (!chunks[cur].has_next) break;
        cur = chunks[cur].next;
      end
      return r;
    endfunction

    function alloc_result_t release_chunk(int unsigned offset);
      alloc_result_t r;
      int unsigned cur;
      r.status = ST_NO_CHUNK;
      r.grant  = '0;
      cur = head;
      for (int steps = 0; steps < TABLE_DEPTH && cur < TABLE_DEPTH; steps++) begin
        if (chunks[cur].in_use && chunks[cur].offset == offset) begin
          chunks[cur].taken = 0;
          merge_free_runs();
          r.status = ST_DONE;
          return r;
        end
        if (!chunks[cur].has_next) break;
        cur = chunks[cur].next;
      end
      return r;
    endfunction

    function void note_request(logic kind, logic [SIZE_W-1:0] size, logic [OFF_W-1:0] off);
      if (kind == REQ_ALLOC) pending.push_back(allocate(size));
      else pending.push_back(release_chunk(off));
    endfunction

    function void check_result(logic [1:0] status, logic [OFF_W-1:0] grant);
      alloc_result_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: status %0d grant %0d", status, grant);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (grant !== e.grant) begin
        $error("grant_offset: expected %0d, got %0d", e.grant, grant);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              req_type_i;
  logic [SIZE_W-1:0] req_size_i;
  logic [OFF_W-1:0]  req_offset_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        status_o;
  logic [OFF_W-1:0]  grant_offset_o;

  alloc_scoreboard   board;
  bit                calm;
  logic [OFF_W-1:0]  granted[$];

  first_fit_page_allocator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .req_type_i(req_type_i), .req_size_i(req_size_i), .req_offset_i(req_offset_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .status_o(status_o), .grant_offset_o(grant_offset_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls except during the calm stretch.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        board.check_result(status_o, grant_offset_o);
        if (status_o == ST_DONE && grant_offset_o != 0) granted.push_back(grant_offset_o);
      end
      out_ready_i <= calm || ($urandom_range(99) >= 18);
    end
  end

  // Sends one request beat, with an optional idle gap first. Valid stays high
  // into the next beat when there is no gap.
  task automatic send_request(logic kind, logic [SIZE_W-1:0] size, logic [OFF_W-1:0] off);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    req_size_i   <= size;
    req_offset_i <= off;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(kind, size, off);
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [OFF_W-1:0] off;
    pick = $urandom_range(99);
    if (pick < 50) begin
      // Mostly small sizes, a few big or raw ones.
      if ($urandom_range(9) < 8)
        send_request(REQ_ALLOC, SIZE_W'(MIN_BLOCK * $urandom_range(1, 32)), 0);
      else send_request(REQ_ALLOC, SIZE_W'($urandom_range(0, 8191)), OFF_W'($urandom));
    end else if (pick < 88 && granted.size() > 0) begin
      off = granted[$urandom_range(granted.size() - 1)];
      send_request(REQ_FREE, SIZE_W'($urandom), off);
    end else if (pick < 94) begin
      send_request(REQ_FREE, SIZE_W'($urandom),
                   OFF_W'(MIN_BLOCK * $urandom_range(0, PAGE_BYTES / MIN_BLOCK - 1)));
    end else begin
      send_request(REQ_FREE, SIZE_W'($urandom), OFF_W'($urandom));
    end
  endtask

  initial begin
    int wait_cycles;
    board        = new();
    board.clear_page();
    calm         = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_ALLOC;
    req_size_i   = '0;
    req_offset_i = '0;
    out_ready_i  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: bad sizes, full page, exact fit, no fit, unknown offset,
    // double free, and merging of neighbors.
    send_request(REQ_ALLOC, 0, 0);
    send_request(REQ_ALLOC, 13'd12, 0);
    send_request(REQ_ALLOC, 13'd4104, 0);
    send_request(REQ_ALLOC, 13'h1FFF, 12'hFFF);
    send_request(REQ_ALLOC, SIZE_W'(PAGE_BYTES), 0);
    send_request(REQ_ALLOC, SIZE_W'(MIN_BLOCK), 0);
    send_request(REQ_FREE, 13'h1FFF, 0);
    send_request(REQ_FREE, 0, 0);
    send_request(REQ_FREE, 0, 12'hFFF);
    send_request(REQ_ALLOC, SIZE_W'(MIN_BLOCK), 0);
    send_request(REQ_ALLOC, 13'd16, 0);
    send_request(REQ_ALLOC, 13'd64, 0);
    send_request(REQ_FREE, 0, 12'd8);
    send_request(REQ_FREE, 0, 12'd8);
    send_request(REQ_FREE, 0, 12'd0);
    send_request(REQ_FREE, 0, 12'd4);
    send_request(REQ_ALLOC, 13'd4008, 0);
    send_request(REQ_ALLOC, SIZE_W'(MIN_BLOCK), 0);
    send_request(REQ_FREE, 0, 12'd24);
    send_request(REQ_FREE, 0, 12'd88);
    send_request(REQ_ALLOC, 13'd4096, 0);

    for (int n = 0; n < 520; n++) begin
      calm = (n >= 200 && n < 260);
      // Allocate forty minimum blocks once, partway through the run, to reach a long list.
      if (n == 300)
        for (int k = 0; k < 40; k++) send_request(REQ_ALLOC, SIZE_W'(MIN_BLOCK), 0);
      send_random();
    end
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (board.pending.size() != 0 && wait_cycles < 4000000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (50) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> first_fit_page_allocator.f
+incdir+rtl
rtl/ffpa_pkg.sv
rtl/ffpa_ram.sv
rtl/ffpa_dp.sv
rtl/ffpa_ctrl.sv
rtl/first_fit_page_allocator.sv
tb/sv/first_fit_page_allocator_test.sv
